// File: design/resp2_pkg.sv
// Shared types and constants for the RESP2 frame encoder.
// No dependencies; used by resp2_bcd_conv and resp2_frame_encoder.
package resp2_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int LEN_PORT_W = 32;
  localparam int SIZE_W = 33;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [3:0] ASCII_DIGIT_HI   = 4'h3;

  typedef enum logic [1:0] {
    TYPE_SIMPLE  = 2'd0,
    TYPE_ERROR   = 2'd1,
    TYPE_BULK    = 2'd2,
    TYPE_INVALID = 2'd3
  } ftype_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_ARG     = 2'd1,
    ERR_PAYLOAD = 2'd2,
    ERR_SPACE   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SIMPLE  = 2'd1,
    PH_BULK    = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_READY,
    ST_CONV,
    ST_CHECK,
    ST_DIGIT,
    ST_HCR,
    ST_HLF,
    ST_CR,
    ST_LF
  } state_t;

  // Decimal digits needed for an unsigned value of lw bits (log10(2) ~ 0.30103).
  function automatic int len_digits(input int lw);
    return (lw * 30103) / 100000 + 1;
  endfunction

endpackage

// File: design/resp2_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on resp2_pkg for the digit count function.
module resp2_bcd_conv #(
  parameter int VALUE_BITS = resp2_pkg::LENGTH_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   start,
  input  logic [VALUE_BITS-1:0]                                  value,
  output logic                                                   busy,
  output logic [4*resp2_pkg::len_digits(VALUE_BITS)-1:0]         bcd,
  output logic [$clog2(resp2_pkg::len_digits(VALUE_BITS)+1)-1:0] digits
);

  localparam int ND = resp2_pkg::len_digits(VALUE_BITS);
  localparam int BCD_W = 4 * ND;
  localparam int DC_W = $clog2(ND + 1);
  localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [VALUE_BITS-1:0] shreg;
  logic [CNT_W-1:0]      cnt;
  logic [BCD_W-1:0]      adj;

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // Significant digits: one more than the highest nonzero digit, at least one.
  always_comb begin
    digits = DC_W'(1);
    for (int i = 1; i < ND; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        digits = DC_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(VALUE_BITS - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= value;
      bcd   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      bcd   <= {adj[BCD_W-2:0], shreg[VALUE_BITS-1]};
    end
  end

endmodule

// File: design/resp2_frame_encoder.sv
// RESP2 frame encoder top level: input/output handshakes, frame sequencer, output register.
// Depends on resp2_pkg and resp2_bcd_conv.
//
// Input channel (in_valid/in_ready): kind 0 is a header (frame_type, body_len,
// buffer_size), kind 1 is one payload byte (data_byte). Output channel
// (out_valid/out_ready): one encoded byte per transaction with frame_last,
// error_code and encoded_size.
// A simple header goes to the size check, which puts its '+' or '-' into the output
// register once that register is free. A bulk header first runs the serial decimal
// converter, one length bit per cycle (length width capped at 32 bits); the size
// check and '$' follow it, then the digits, CR and LF one per cycle while the
// receiver takes them. A bad type answers in the cycle after acceptance.
// Payload bytes pass at one per cycle while the receiver takes them, each on the
// output in the cycle after acceptance; a frame's last byte is followed by CR and LF.
// The block takes no new item while it is still emitting the bytes of an earlier one.
// A single output register holds each result; when the receiver stalls it holds its
// contents, and the input is accepted again as soon as that register is taken.
// Reset clears the sequencer, the frame phase, the byte count and the output valid.
module resp2_frame_encoder #(
  parameter int LENGTH_BITS = resp2_pkg::LENGTH_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [1:0]                        frame_type,
  input  logic [resp2_pkg::LEN_PORT_W-1:0]  body_len,
  input  logic [resp2_pkg::SIZE_W-1:0]      buffer_size,
  input  logic [resp2_pkg::BYTE_W-1:0]      data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [resp2_pkg::BYTE_W-1:0]      out_byte,
  output logic                              frame_last,
  output logic [1:0]                        error_code,
  output logic [resp2_pkg::SIZE_W-1:0]      encoded_size
);

  localparam int LEN_W = (LENGTH_BITS < resp2_pkg::LEN_PORT_W) ?
                         LENGTH_BITS : resp2_pkg::LEN_PORT_W;
  localparam int ND = resp2_pkg::len_digits(LEN_W);
  localparam int DC_W = $clog2(ND + 1);
  localparam int IDX_W = $clog2(ND);
  localparam int SIZE_W = resp2_pkg::SIZE_W;
  localparam int BYTE_W = resp2_pkg::BYTE_W;

  resp2_pkg::state_t state, state_next;
  resp2_pkg::phase_t phase, phase_next;
  resp2_pkg::ftype_t ftype, ftype_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [SIZE_W-1:0] cap, cap_next;
  logic [SIZE_W-1:0] need, need_next;
  logic [SIZE_W-1:0] tail_size, tail_size_next;
  logic [IDX_W-1:0]  dig_idx, dig_idx_next;

  logic              out_load;
  logic [BYTE_W-1:0] out_byte_next;
  logic              frame_last_next;
  resp2_pkg::err_t   error_code_next;
  logic [SIZE_W-1:0] encoded_size_next;

  logic              can_load;
  logic              accept;
  logic              conv_start;
  logic              conv_busy;
  logic [4*ND-1:0]   bcd;
  logic [DC_W-1:0]   nd;
  logic [SIZE_W-1:0] need_calc;
  logic [LEN_W-1:0]  bl_dec;

  resp2_bcd_conv #(
    .VALUE_BITS(LEN_W)
  ) u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .value  (body_len[LEN_W-1:0]),
    .busy   (conv_busy),
    .bcd    (bcd),
    .digits (nd)
  );

  assign can_load = !out_valid || out_ready;
  assign in_ready = (state == resp2_pkg::ST_READY) && can_load;
  assign accept = in_valid && in_ready;
  assign conv_start = accept && !kind && (frame_type == resp2_pkg::TYPE_BULK);
  assign bl_dec = bytes_left - LEN_W'(1);

  always_comb begin
    if (ftype == resp2_pkg::TYPE_BULK) begin
      need_calc = SIZE_W'(len) + SIZE_W'(nd) + SIZE_W'(5);
    end else begin
      need_calc = SIZE_W'(len) + SIZE_W'(3);
    end
  end

  always_comb begin
    state_next        = state;
    phase_next        = phase;
    ftype_next        = ftype;
    bytes_left_next   = bytes_left;
    len_next          = len;
    cap_next          = cap;
    need_next         = need;
    tail_size_next    = tail_size;
    dig_idx_next      = dig_idx;
    out_load          = 1'b0;
    out_byte_next     = '0;
    frame_last_next   = 1'b0;
    error_code_next   = resp2_pkg::ERR_NONE;
    encoded_size_next = '0;

    unique case (state)
      resp2_pkg::ST_READY: begin
        if (accept && !kind) begin
          // A header abandons any open frame.
          phase_next      = resp2_pkg::PH_IDLE;
          bytes_left_next = '0;
          ftype_next      = resp2_pkg::ftype_t'(frame_type);
          len_next        = body_len[LEN_W-1:0];
          cap_next        = buffer_size;
          if (frame_type == resp2_pkg::TYPE_INVALID) begin
            out_load        = 1'b1;
            frame_last_next = 1'b1;
            error_code_next = resp2_pkg::ERR_ARG;
          end else if (frame_type == resp2_pkg::TYPE_BULK) begin
            state_next = resp2_pkg::ST_CONV;
          end else begin
            state_next = resp2_pkg::ST_CHECK;
          end
        end else if (accept) begin
          if (phase == resp2_pkg::PH_IDLE || bytes_left == '0) begin
            phase_next      = resp2_pkg::PH_IDLE;
            bytes_left_next = '0;
          end else begin
            bytes_left_next = bl_dec;
            if (phase == resp2_pkg::PH_DISCARD) begin
              if (bl_dec == '0) begin
                phase_next = resp2_pkg::PH_IDLE;
              end
            end else if (phase == resp2_pkg::PH_SIMPLE &&
                         (data_byte == resp2_pkg::CH_CR || data_byte == resp2_pkg::CH_LF)) begin
              out_load        = 1'b1;
              frame_last_next = 1'b1;
              error_code_next = resp2_pkg::ERR_PAYLOAD;
              phase_next = (bl_dec == '0) ? resp2_pkg::PH_IDLE : resp2_pkg::PH_DISCARD;
            end else begin
              out_load      = 1'b1;
              out_byte_next = data_byte;
              if (bl_dec == '0) begin
                phase_next     = resp2_pkg::PH_IDLE;
                tail_size_next = '0;
                state_next     = resp2_pkg::ST_CR;
              end
            end
          end
        end
      end

      resp2_pkg::ST_CONV: begin
        if (!conv_busy) begin
          state_next = resp2_pkg::ST_CHECK;
        end
      end

      resp2_pkg::ST_CHECK: begin
        if (can_load) begin
          out_load          = 1'b1;
          encoded_size_next = need_calc;
          need_next         = need_calc;
          if (cap < need_calc) begin
            frame_last_next = 1'b1;
            error_code_next = resp2_pkg::ERR_SPACE;
            state_next      = resp2_pkg::ST_READY;
          end else begin
            if (len != '0) begin
              phase_next = (ftype == resp2_pkg::TYPE_BULK) ?
                           resp2_pkg::PH_BULK : resp2_pkg::PH_SIMPLE;
              bytes_left_next = len;
            end
            priority if (ftype == resp2_pkg::TYPE_BULK) begin
              out_byte_next = resp2_pkg::CH_DOLLAR;
              dig_idx_next  = IDX_W'(nd - DC_W'(1));
              state_next    = resp2_pkg::ST_DIGIT;
            end else if (len == '0) begin
              out_byte_next  = (ftype == resp2_pkg::TYPE_SIMPLE) ?
                               resp2_pkg::CH_PLUS : resp2_pkg::CH_MINUS;
              tail_size_next = need_calc;
              state_next     = resp2_pkg::ST_CR;
            end else begin
              out_byte_next = (ftype == resp2_pkg::TYPE_SIMPLE) ?
                              resp2_pkg::CH_PLUS : resp2_pkg::CH_MINUS;
              state_next    = resp2_pkg::ST_READY;
            end
          end
        end
      end

      resp2_pkg::ST_DIGIT: begin
        if (can_load) begin
          out_load          = 1'b1;
          out_byte_next     = {resp2_pkg::ASCII_DIGIT_HI, bcd[{dig_idx, 2'b00} +: 4]};
          encoded_size_next = need;
          if (dig_idx == '0) begin
            state_next = resp2_pkg::ST_HCR;
          end else begin
            dig_idx_next = dig_idx - IDX_W'(1);
          end
        end
      end

      resp2_pkg::ST_HCR: begin
        if (can_load) begin
          out_load          = 1'b1;
          out_byte_next     = resp2_pkg::CH_CR;
          encoded_size_next = need;
          state_next        = resp2_pkg::ST_HLF;
        end
      end

      resp2_pkg::ST_HLF: begin
        if (can_load) begin
          out_load          = 1'b1;
          out_byte_next     = resp2_pkg::CH_LF;
          encoded_size_next = need;
          // Empty bulk payload still gets its own closing CR LF.
          if (len == '0) begin
            tail_size_next = need;
            state_next     = resp2_pkg::ST_CR;
          end else begin
            state_next = resp2_pkg::ST_READY;
          end
        end
      end

      resp2_pkg::ST_CR: begin
        if (can_load) begin
          out_load          = 1'b1;
          out_byte_next     = resp2_pkg::CH_CR;
          encoded_size_next = tail_size;
          state_next        = resp2_pkg::ST_LF;
        end
      end

      resp2_pkg::ST_LF: begin
        if (can_load) begin
          out_load          = 1'b1;
          out_byte_next     = resp2_pkg::CH_LF;
          frame_last_next   = 1'b1;
          encoded_size_next = tail_size;
          state_next        = resp2_pkg::ST_READY;
        end
      end

      default: begin
        state_next = resp2_pkg::ST_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= resp2_pkg::ST_READY;
      phase      <= resp2_pkg::PH_IDLE;
      bytes_left <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ftype     <= ftype_next;
    len       <= len_next;
    cap       <= cap_next;
    need      <= need_next;
    tail_size <= tail_size_next;
    dig_idx   <= dig_idx_next;
    if (out_load) begin
      out_byte     <= out_byte_next;
      frame_last   <= frame_last_next;
      error_code   <= error_code_next;
      encoded_size <= encoded_size_next;
    end
  end

  // An open frame always has payload bytes still expected.
  a_phase_count: assert property (@(posedge clk) disable iff (rst)
    (phase != resp2_pkg::PH_IDLE) |-> (bytes_left != '0))
    else $error("frame phase open with no bytes left");

  // Every error result closes the frame.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != resp2_pkg::ERR_NONE) |-> frame_last)
    else $error("error result without frame_last");

  // Bad type reports no size.
  a_arg_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code == resp2_pkg::ERR_ARG) |-> (encoded_size == '0))
    else $error("invalid argument result carries a size");

  // The converter only runs while the sequencer waits on it.
  a_conv_wait: assert property (@(posedge clk) disable iff (rst)
    conv_busy |-> (state == resp2_pkg::ST_CONV))
    else $error("converter busy outside conversion state");

endmodule
